@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/rgbw_fade_pkg.sv @@
// Shared types, constants and codes of the RGBW fade engine.
package rgbw_fade_pkg;

    localparam int CHANNEL_COUNT_DEF = 4;
    localparam int LEVEL_BITS_DEF    = 16;

    localparam int FIELD_BITS   = 16;
    localparam int OUT_FIELDS   = 4;
    localparam int STEP_BITS    = 8;
    localparam int ELAPSED_BITS = 17;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 8'd2;

    // Input tdata layout
    localparam int IN_MODE_LSB  = 0;
    localparam int IN_DELAY_LSB = 2;
    localparam int IN_DUR_LSB   = 18;
    localparam int IN_TGT_LSB   = 34;
    localparam int IN_TDATA_BITS  = 104;
    localparam int OUT_TDATA_BITS = 64;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_START    = 2'd1;
    localparam logic [1:0] KIND_ABORT    = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [1:0] MODE_IMMEDIATE = 2'd0;
    localparam logic [1:0] MODE_FADE      = 2'd1;
    localparam logic [1:0] MODE_WAVEFORM  = 2'd2;
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;

    typedef struct packed {
        logic load_start;
        logic dec_wait;
        logic apply_imm;
        logic begin_fade;
        logic adv_elapsed;
        logic final_target;
        logic div_start;
        logic div_step;
        logic write_ch;
        logic reload_wait;
        logic emit;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic       start_delay_zero;
        logic       wait_le1;
        logic [1:0] mode;
        logic       elapsed_lt_len;
        logic       div_done;
        logic       out_free;
    } t_status;

endpackage

@@ hdl/rgbw_linear_fade_engine_top.sv @@
// RGBW linear fade engine: top level joining controller and datapath.
// A plain tick or abort stays in idle; an immediate start or delay-ending tick passes S_BEGIN,
// a fade-ending tick S_STEP and S_CMP, a fade step S_STEP, S_CMP, then S_MUL and S_DIV per
// channel in turn via the shared multiply and bit-serial divider; results leave by S_EMIT.
// One request at a time; the next is taken once the result sits in the output register.
// Reset: synchronous active low; colours, wait and elapsed clear, step_ticks returns to 2.
module rgbw_linear_fade_engine_top
    import rgbw_fade_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // mode[1:0], delay_ticks[17:2], fade_len[33:18], target_red[49:34],
    // target_green[65:50], target_blue[81:66], target_white[97:82], zero pad
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // level_red[15:0], level_green[31:16], level_blue[47:32], level_white[63:48]
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic                      m_axis_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [STEP_BITS-1:0]      cfg_data
);
    `include "assert_macros.svh"

    localparam int CH_BITS = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    t_cmd               cmd;
    t_status            status;
    logic [CH_BITS-1:0] ch;

    assign cfg_ready = 1'b1;

    rgbw_fade_ctrl #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .CH_BITS      (CH_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .i_status(status),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd),
        .o_ch    (ch)
    );

    rgbw_fade_datapath #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .LEVEL_BITS   (LEVEL_BITS),
        .CH_BITS      (CH_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tdata    (s_axis_tdata),
        .i_cfg_we   (cfg_valid),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd),
        .i_ch       (ch),
        .i_out_ready(m_axis_tready),
        .o_status   (status),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

    // Never overwrite a result that has not been taken
    `ASSERT_IMPL(a_emit_free, cmd.emit, !m_axis_tvalid || m_axis_tready)
    // A taken result with nothing new behind it leaves the output empty
    `ASSERT_NEXT(a_out_drain, m_axis_tvalid && m_axis_tready && !cmd.emit, !m_axis_tvalid)
    // No divider step once the quotient is complete
    `ASSERT_IMPL(a_div_bound, cmd.div_step, !status.div_done)

endmodule

@@ hdl/rgbw_fade_datapath.sv @@
// Datapath of the fade engine: colour store, counters, multiplier, divider, output register.
module rgbw_fade_datapath
    import rgbw_fade_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
    parameter int CH_BITS       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [IN_TDATA_BITS-1:0]  i_tdata,
    input  logic                      i_cfg_we,
    input  logic [STEP_BITS-1:0]      i_cfg_data,
    input  t_cmd                      i_cmd,
    input  logic [CH_BITS-1:0]        i_ch,
    input  logic                      i_out_ready,
    output t_status                   o_status,
    output logic                      o_out_valid,
    output logic [OUT_TDATA_BITS-1:0] o_out_data,
    output logic                      o_out_last
);

    localparam int PW  = LEVEL_BITS + FIELD_BITS;
    localparam int CNB = $clog2(PW + 1);

    logic [LEVEL_BITS-1:0] r_present [CHANNEL_COUNT];
    logic [LEVEL_BITS-1:0] r_origin  [CHANNEL_COUNT];
    logic [LEVEL_BITS-1:0] r_mag     [CHANNEL_COUNT];
    logic                  r_down    [CHANNEL_COUNT];
    logic [LEVEL_BITS-1:0] r_pend    [CHANNEL_COUNT];
    logic [LEVEL_BITS-1:0] n_tgt     [CHANNEL_COUNT];

    logic [1:0]              r_mode;
    logic [FIELD_BITS-1:0]   r_len;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [FIELD_BITS-1:0]   r_wait;
    logic [STEP_BITS-1:0]    r_step;
    logic [STEP_BITS-1:0]    step_len;
    logic [PW-1:0]           prod;
    logic [PW-1:0]           r_dq;
    logic [FIELD_BITS:0]     r_rem;
    logic [CNB-1:0]          r_cnt;
    logic [FIELD_BITS:0]     rem_sh;
    logic [FIELD_BITS:0]     rem_sub;
    logic [LEVEL_BITS-1:0]   quo;
    logic                    r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;
    logic                    r_out_last;
    logic [FIELD_BITS-1:0]   in_delay;

    assign in_delay = i_tdata[IN_DELAY_LSB +: FIELD_BITS];
    assign step_len = (r_step == '0) ? STEP_BITS'(1) : r_step;

    // Unpack and mask targets; channels past the fourth field read zero
    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            if (i < OUT_FIELDS) begin
                n_tgt[i] = i_tdata[IN_TGT_LSB + i*FIELD_BITS +: LEVEL_BITS];
            end else begin
                n_tgt[i] = '0;
            end
        end
    end

    // Product of the selected channel's magnitude and the elapsed count
    assign prod = PW'(r_mag[i_ch]) * PW'(r_elapsed[FIELD_BITS-1:0]);

    // One restoring division step
    assign rem_sh  = {r_rem[FIELD_BITS-1:0], r_dq[PW-1]};
    assign rem_sub = rem_sh - {1'b0, r_len};
    assign quo     = r_dq[LEVEL_BITS-1:0];

    assign o_status.start_delay_zero = (in_delay == '0);
    assign o_status.wait_le1         = (r_wait <= FIELD_BITS'(1));
    assign o_status.mode             = r_mode;
    assign o_status.elapsed_lt_len   = (r_elapsed < {1'b0, r_len});
    assign o_status.div_done         = (r_cnt == CNB'(PW));
    assign o_status.out_free         = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_present[i] <= '0;
                r_origin[i]  <= '0;
                r_mag[i]     <= '0;
                r_down[i]    <= 1'b0;
                r_pend[i]    <= '0;
            end
            r_mode      <= '0;
            r_len       <= '0;
            r_elapsed   <= '0;
            r_wait      <= '0;
            r_step      <= STEP_RESET;
            r_cnt       <= CNB'(PW);
            r_out_valid <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            // Latch a start request
            if (i_cmd.load_start) begin
                r_mode <= i_tdata[IN_MODE_LSB +: 2];
                r_len  <= i_tdata[IN_DUR_LSB +: FIELD_BITS];
                r_wait <= in_delay;
                for (int i = 0; i < CHANNEL_COUNT; i++) begin
                    r_pend[i] <= n_tgt[i];
                end
            end
            // Count down the wait
            if (i_cmd.dec_wait && r_wait != '0) begin
                r_wait <= r_wait - FIELD_BITS'(1);
            end
            if (i_cmd.reload_wait) begin
                r_wait <= FIELD_BITS'(step_len);
            end
            if (i_cmd.apply_imm) begin
                for (int i = 0; i < CHANNEL_COUNT; i++) begin
                    r_present[i] <= r_pend[i];
                end
            end
            // Set up a fade from the present colour
            if (i_cmd.begin_fade) begin
                for (int i = 0; i < CHANNEL_COUNT; i++) begin
                    r_origin[i] <= r_present[i];
                    if (r_pend[i] >= r_present[i]) begin
                        r_mag[i]  <= r_pend[i] - r_present[i];
                        r_down[i] <= 1'b0;
                    end else begin
                        r_mag[i]  <= r_present[i] - r_pend[i];
                        r_down[i] <= 1'b1;
                    end
                end
                r_elapsed <= '0;
                r_wait    <= FIELD_BITS'(step_len);
            end
            if (i_cmd.adv_elapsed) begin
                r_elapsed <= r_elapsed + ELAPSED_BITS'(step_len);
            end
            if (i_cmd.final_target) begin
                for (int i = 0; i < CHANNEL_COUNT; i++) begin
                    r_present[i] <= r_down[i] ? r_origin[i] - r_mag[i]
                                              : r_origin[i] + r_mag[i];
                end
            end
            // Load the product into the divider, then divide by the fade length
            if (i_cmd.div_start) begin
                r_dq  <= prod;
                r_rem <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                if (!rem_sub[FIELD_BITS]) begin
                    r_rem <= rem_sub;
                    r_dq  <= {r_dq[PW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_dq  <= {r_dq[PW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CNB'(1);
            end
            if (i_cmd.write_ch) begin
                r_present[i_ch] <= r_down[i_ch] ? r_origin[i_ch] - quo : r_origin[i_ch] + quo;
            end
            // Output register
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_last  <= i_cmd.fin;
                for (int i = 0; i < OUT_FIELDS; i++) begin
                    if (i < CHANNEL_COUNT) begin
                        r_out_data[i*FIELD_BITS +: FIELD_BITS] <= FIELD_BITS'(r_present[i]);
                    end else begin
                        r_out_data[i*FIELD_BITS +: FIELD_BITS] <= '0;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

@@ hdl/rgbw_fade_ctrl.sv @@
// Controller of the fade engine: request decode, phase tracking and step sequencing.
module rgbw_fade_ctrl
    import rgbw_fade_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int CH_BITS       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_kind,
    input  t_status            i_status,
    output logic               o_ready,
    output t_cmd               o_cmd,
    output logic [CH_BITS-1:0] o_ch
);

    typedef enum logic [2:0] {
        S_IDLE, S_BEGIN, S_STEP, S_CMP, S_MUL, S_DIV, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE, PH_DELAY, PH_FADE
    } t_phase;

    t_state             r_state;
    t_phase             r_phase;
    logic [CH_BITS-1:0] r_ch;
    logic               r_fin;
    logic               acc;
    logic               last_ch;

    assign acc     = i_valid && (r_state == S_IDLE);
    assign last_ch = (r_ch == CH_BITS'(CHANNEL_COUNT - 1));
    assign o_ready = (r_state == S_IDLE);
    assign o_ch    = r_ch;

    // Decode commands for the datapath
    always_comb begin
        o_cmd     = '0;
        o_cmd.fin = r_fin;
        case (r_state)
            S_IDLE: begin
                if (acc && i_kind == KIND_START) begin
                    o_cmd.load_start = 1'b1;
                end
                if (acc && i_kind == KIND_TICK && r_phase != PH_IDLE) begin
                    o_cmd.dec_wait = 1'b1;
                end
            end
            S_BEGIN: begin
                o_cmd.apply_imm  = (i_status.mode == MODE_IMMEDIATE);
                o_cmd.begin_fade = (i_status.mode == MODE_FADE);
            end
            S_STEP:  o_cmd.adv_elapsed = 1'b1;
            S_CMP: begin
                o_cmd.final_target = !i_status.elapsed_lt_len;
            end
            S_MUL:   o_cmd.div_start = 1'b1;
            S_DIV: begin
                o_cmd.div_start   = 1'b0;
                o_cmd.div_step    = !i_status.div_done;
                o_cmd.write_ch    = i_status.div_done;
                o_cmd.reload_wait = i_status.div_done && last_ch;
            end
            S_EMIT:  o_cmd.emit = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // Hold state, phase, channel index and finish flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_ch    <= '0;
            r_fin   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        case (i_kind)
                            KIND_START: begin
                                if (i_status.start_delay_zero) begin
                                    r_phase <= PH_IDLE;
                                    r_state <= S_BEGIN;
                                end else begin
                                    r_phase <= PH_DELAY;
                                end
                            end
                            KIND_ABORT: r_phase <= PH_IDLE;
                            KIND_TICK: begin
                                if (i_status.wait_le1) begin
                                    if (r_phase == PH_DELAY) begin
                                        r_state <= S_BEGIN;
                                    end else if (r_phase == PH_FADE) begin
                                        r_state <= S_STEP;
                                    end
                                end
                            end
                            default: r_phase <= r_phase;
                        endcase
                    end
                end
                S_BEGIN: begin
                    if (i_status.mode == MODE_IMMEDIATE) begin
                        r_phase <= PH_IDLE;
                        r_fin   <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (i_status.mode == MODE_FADE) begin
                        r_phase <= PH_FADE;
                        r_state <= S_IDLE;
                    end else begin
                        r_phase <= PH_IDLE;
                        r_state <= S_IDLE;
                    end
                end
                S_STEP: r_state <= S_CMP;
                S_CMP: begin
                    if (i_status.elapsed_lt_len) begin
                        r_ch    <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_phase <= PH_IDLE;
                        r_fin   <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (i_status.div_done) begin
                        if (last_ch) begin
                            r_fin   <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_ch    <= r_ch + CH_BITS'(1);
                            r_state <= S_MUL;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ test/rgbw_fade_checker.sv @@
// Checker for the RGBW fade engine: it watches the channels, predicts the levels and compares.
`timescale 1ns / 1ps

module rgbw_fade_checker
    import rgbw_fade_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_valid,
    input  logic                      i_s_ready,
    input  logic [IN_TDATA_BITS-1:0]  i_s_data,
    input  logic [1:0]                i_s_kind,
    input  logic                      i_m_valid,
    input  logic                      i_m_ready,
    input  logic [OUT_TDATA_BITS-1:0] i_m_data,
    input  logic                      i_m_last,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [STEP_BITS-1:0]      i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef enum logic [1:0] {FADE_IDLE, FADE_DELAY, FADE_RUN} fade_phase_t;

    typedef struct packed {
        logic [3:0][15:0] level;
        logic             fin;
    } level_set_t;

    localparam string CHAN_NAME [4] = '{"level_red", "level_green", "level_blue", "level_white"};

    level_set_t       expected_levels [$];
    logic [7:0]       step_reg;
    logic [3:0][15:0] colour, origin, magnitude, target;
    logic [3:0]       downward;
    logic [15:0]      fade_len, wait_cnt;
    logic [16:0]      elapsed;
    logic [1:0]       target_mode;
    fade_phase_t      fade_phase;

    assign o_pending = expected_levels.size();

    function automatic logic [16:0] step_len();
        return (step_reg == 8'd0) ? 17'd1 : {9'd0, step_reg};
    endfunction

    task automatic record_levels(input logic fin);
        level_set_t s;
        s.level = colour;
        s.fin   = fin;
        expected_levels.push_back(s);
    endtask

    // Start the held transition once the delay has run out
    task automatic begin_transition();
        if (target_mode == MODE_IMMEDIATE) begin
            colour     = target;
            fade_phase = FADE_IDLE;
            record_levels(1'b1);
        end else if (target_mode == MODE_FADE) begin
            for (int c = 0; c < 4; c++) begin
                origin[c]   = colour[c];
                downward[c] = target[c] < colour[c];
                magnitude[c] = downward[c] ? colour[c] - target[c] : target[c] - colour[c];
            end
            elapsed    = '0;
            wait_cnt   = step_len();
            fade_phase = FADE_RUN;
        end else begin
            fade_phase = FADE_IDLE;
        end
    endtask

    // Advance the fade by one step, or land on the target exactly
    task automatic advance_fade();
        logic [63:0] part;
        elapsed = elapsed + step_len();
        if (elapsed < {1'b0, fade_len}) begin
            for (int c = 0; c < 4; c++) begin
                part = (64'(magnitude[c]) * 64'(elapsed)) / 64'(fade_len);
                colour[c] = downward[c] ? origin[c] - part[15:0] : origin[c] + part[15:0];
            end
            wait_cnt = step_len();
            record_levels(1'b0);
        end else begin
            for (int c = 0; c < 4; c++)
                colour[c] = downward[c] ? origin[c] - magnitude[c] : origin[c] + magnitude[c];
            fade_phase = FADE_IDLE;
            record_levels(1'b1);
        end
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [IN_TDATA_BITS-1:0] d);
        if (kind == KIND_START) begin
            fade_phase  = FADE_IDLE;
            target_mode = d[IN_MODE_LSB +: 2];
            fade_len    = d[IN_DUR_LSB +: 16];
            for (int c = 0; c < 4; c++)
                target[c] = d[IN_TGT_LSB + 16*c +: 16];
            wait_cnt = d[IN_DELAY_LSB +: 16];
            if (wait_cnt != 0)
                fade_phase = FADE_DELAY;
            else
                begin_transition();
        end else if (kind == KIND_ABORT) begin
            fade_phase = FADE_IDLE;
        end else if (kind == KIND_TICK && fade_phase != FADE_IDLE) begin
            if (wait_cnt > 0)
                wait_cnt--;
            if (wait_cnt == 0) begin
                if (fade_phase == FADE_DELAY)
                    begin_transition();
                else
                    advance_fade();
            end
        end
    endtask

    // Follow requests, register writes and results at each edge
    always @(posedge i_clk) begin
        level_set_t exp_set;
        if (!i_rst_n) begin
            step_reg    = STEP_RESET;
            colour      = '0;
            origin      = '0;
            magnitude   = '0;
            target      = '0;
            downward    = '0;
            fade_len    = '0;
            elapsed     = '0;
            wait_cnt    = '0;
            target_mode = '0;
            fade_phase  = FADE_IDLE;
            expected_levels.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                step_reg = i_cfg_data;
            if (i_s_valid && i_s_ready)
                predict_request(i_s_kind, i_s_data);
            if (i_m_valid && i_m_ready) begin
                if (expected_levels.size() == 0) begin
                    $error("unexpected result: levels %h finished %b", i_m_data, i_m_last);
                    o_fail_count++;
                end else begin
                    exp_set = expected_levels.pop_front();
                    for (int c = 0; c < 4; c++)
                        if (i_m_data[16*c +: 16] !== exp_set.level[c]) begin
                            $error("%s: expected %h, actual %h", CHAN_NAME[c],
                                   exp_set.level[c], i_m_data[16*c +: 16]);
                            o_fail_count++;
                        end
                    if (i_m_last !== exp_set.fin) begin
                        $error("finished: expected %b, actual %b", exp_set.fin, i_m_last);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// Top of the RGBW fade engine bench: stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module testbench;
    import rgbw_fade_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 300;
    localparam int PHASE_ITEMS  = 300;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic [1:0]                s_axis_tuser = KIND_TICK;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [STEP_BITS-1:0]      cfg_data = '0;

    int  fail_count, levels_pending, idle_cycles, item_count, stall_left;
    bit  calm_tx, calm_rx;

    always #10 i_clk = ~i_clk;

    rgbw_linear_fade_engine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    rgbw_fade_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_kind(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .i_m_last(m_axis_tlast),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(levels_pending)
    );

    // Stall the result side at random, mostly briefly
    always @(negedge i_clk) begin
        if (!i_rst_n || calm_rx) begin
            m_axis_tready = i_rst_n;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready = 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Abort the run when no channel moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("rgbw_linear_fade_engine_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold one request on the input channel until it is taken
    task automatic send_request(input logic [1:0] kind, input logic [IN_TDATA_BITS-1:0] d);
        int gap;
        bit rdy;
        gap = 0;
        if (!calm_tx) begin
            gap = $urandom_range(0, 99);
            gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        end
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = d;
        do begin
            #1 rdy = s_axis_tready;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!rdy);
        if (kind != KIND_RESERVED)
            item_count++;
    endtask

    task automatic send_start(input logic [1:0] mode, input logic [15:0] delay,
                              input logic [15:0] dur, input logic [63:0] tgt);
        send_request(KIND_START, {6'd0, tgt, dur, delay, mode});
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(KIND_TICK, {$urandom, $urandom, $urandom, $urandom});
    endtask

    function automatic logic [15:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        return (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
    endfunction

    // Drain outstanding results and let the block settle, then write the step register
    task automatic write_step(input logic [7:0] v);
        bit rdy;
        s_axis_tvalid = 1'b0;
        while (levels_pending != 0) @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do begin
            #1 rdy = cfg_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!rdy);
        cfg_valid = 1'b0;
    endtask

    // One random sequence: mostly a well-formed start and enough ticks, sometimes noise
    task automatic random_sequence(input logic [7:0] step);
        int r, n, eff_step;
        logic [1:0]  mode;
        logic [15:0] delay, dur;
        eff_step = (step == 0) ? 1 : step;
        calm_tx  = ($urandom_range(0, 4) == 0);
        calm_rx  = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            send_request(2'($urandom_range(0, 3)),
                         {$urandom, $urandom, $urandom, $urandom});
            return;
        end
        r     = $urandom_range(0, 99);
        mode  = (r < 55) ? MODE_FADE : (r < 85) ? MODE_IMMEDIATE : 2'($urandom_range(2, 3));
        r     = $urandom_range(0, 99);
        delay = (r < 65) ? 16'd0 : (r < 97) ? 16'($urandom_range(1, 4)) : 16'($urandom);
        r     = $urandom_range(0, 99);
        dur   = (r < 10) ? 16'd0 : (r < 95) ? 16'($urandom_range(1, 40)) : 16'($urandom);
        send_start(mode, delay, dur, {pick_level(), pick_level(), pick_level(), pick_level()});
        n = delay + ((mode == MODE_FADE) ? dur + eff_step : 0) + 1;
        if (n > 90)
            n = 90;
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(0, n);
        send_ticks(n);
        if ($urandom_range(0, 9) == 0)
            send_request(KIND_ABORT, {$urandom, $urandom, $urandom, $urandom});
    endtask

    initial begin
        logic [7:0] step_plan [5];
        step_plan = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(3, 20)), 8'd2};
        item_count = 0;
        stall_left = 0;
        calm_tx    = 1'b0;
        calm_rx    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: immediate extremes, zero duration, downward fade, odd modes, long waits
        send_start(MODE_IMMEDIATE, 16'd0, 16'd0, {64{1'b1}});
        send_start(MODE_IMMEDIATE, 16'd0, 16'hFFFF, 64'd0);
        send_start(MODE_FADE, 16'd0, 16'd0, {64{1'b1}});
        send_ticks(2);
        send_start(MODE_FADE, 16'd0, 16'd5, 64'h0000_8000_1234_FFFF);
        send_ticks(6);
        send_start(MODE_WAVEFORM, 16'd0, 16'd3, 64'h1111_2222_3333_4444);
        send_start(MODE_UNDEFINED, 16'd0, 16'd3, 64'h5555_6666_7777_8888);
        send_ticks(1);
        send_request(KIND_ABORT, '0);
        send_request(KIND_RESERVED, {IN_TDATA_BITS{1'b1}});
        send_start(MODE_IMMEDIATE, 16'hFFFF, 16'd7, 64'hAAAA_5555_AAAA_5555);
        send_request(KIND_ABORT, '0);
        send_start(MODE_FADE, 16'd2, 16'hFFFF, {64{1'b1}});
        send_ticks(3);
        send_request(KIND_ABORT, '0);

        // Random phases, each under its own step setting
        foreach (step_plan[p]) begin
            write_step(step_plan[p]);
            item_count = 0;
            while (item_count < PHASE_ITEMS)
                random_sequence(step_plan[p]);
        end

        calm_rx       = 1'b1;
        s_axis_tvalid = 1'b0;
        while (levels_pending != 0) @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
        if (fail_count == 0 && levels_pending == 0)
            $display("rgbw_linear_fade_engine_top verification clean");
        else
            $display("rgbw_linear_fade_engine_top verification failed");
        $finish;
    end

endmodule
